>>> hdl/nsw_pkg.sv
package nsw_pkg;

   localparam int MAX_SEGMENTS = 64;
   localparam int COORD_BITS   = 20;
   localparam int IDX_BITS     = $clog2(MAX_SEGMENTS);
   localparam int CNT_BITS     = $clog2(MAX_SEGMENTS + 1);
   localparam int SPAN_BITS    = 5;
   localparam int ABS_BITS     = COORD_BITS + 1;
   localparam int SQ_BITS      = 2 * ABS_BITS;
   localparam int DIST_BITS    = SQ_BITS + 2;
   localparam int WIN_BITS     = ((IDX_BITS > SPAN_BITS) ? IDX_BITS : SPAN_BITS) + 1;

   localparam logic [SPAN_BITS-1:0] SPAN_RESET = SPAN_BITS'(1);

   // command codes
   localparam logic [1:0] CMD_CLEAR  = 2'd0;
   localparam logic [1:0] CMD_APPEND = 2'd1;
   localparam logic [1:0] CMD_QUERY  = 2'd2;

   typedef struct packed {
      logic signed [COORD_BITS-1:0] x;
      logic signed [COORD_BITS-1:0] y;
      logic signed [COORD_BITS-1:0] z;
   } centre_type;

   typedef struct packed {
      logic [1:0]                   command;
      logic signed [COORD_BITS-1:0] pos_x;
      logic signed [COORD_BITS-1:0] pos_y;
      logic signed [COORD_BITS-1:0] pos_z;
   } req_type;

   typedef struct packed {
      logic                found;
      logic [IDX_BITS-1:0] closest_index;
      logic [IDX_BITS-1:0] segment_index;
      logic                last;
   } rsp_type;

   // tag that travels with each centre through the distance pipeline
   typedef struct packed {
      logic                valid;
      logic                last;
      logic [IDX_BITS-1:0] index;
   } scan_tag_type;

endpackage

>>> hdl/nsw_ram.sv
module nsw_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   parameter int ADDR_BITS = $clog2(DEPTH)
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [ADDR_BITS-1:0] wr_addr,
   input  logic [WIDTH-1:0]     wr_data,
   input  logic [ADDR_BITS-1:0] rd_addr,
   output logic [WIDTH-1:0]     rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hdl/nsw_dist.sv
module nsw_dist
   import nsw_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  scan_tag_type         in_tag,
   input  centre_type           centre,
   input  centre_type           point,
   output scan_tag_type         out_tag,
   output logic [DIST_BITS-1:0] out_dist
);

   // stage 1: absolute differences
   logic signed [ABS_BITS-1:0] dx, dy, dz;
   logic [ABS_BITS-1:0] ax_in, ay_in, az_in;
   logic [ABS_BITS-1:0] ax_ff, ay_ff, az_ff;
   // stage 2: squares
   logic [SQ_BITS-1:0] sx_ff, sy_ff, sz_ff;
   // stage 3: sum
   logic [DIST_BITS-1:0] dist_ff;
   scan_tag_type tag1_ff, tag2_ff, tag3_ff;

   always_comb begin
      dx = ABS_BITS'(centre.x) - ABS_BITS'(point.x);
      dy = ABS_BITS'(centre.y) - ABS_BITS'(point.y);
      dz = ABS_BITS'(centre.z) - ABS_BITS'(point.z);
      ax_in = dx[ABS_BITS-1] ? (~dx + 1'b1) : dx;
      ay_in = dy[ABS_BITS-1] ? (~dy + 1'b1) : dy;
      az_in = dz[ABS_BITS-1] ? (~dz + 1'b1) : dz;
   end

   always_ff @(posedge clock) begin
      ax_ff   <= ax_in;
      ay_ff   <= ay_in;
      az_ff   <= az_in;
      sx_ff   <= SQ_BITS'(ax_ff) * SQ_BITS'(ax_ff);
      sy_ff   <= SQ_BITS'(ay_ff) * SQ_BITS'(ay_ff);
      sz_ff   <= SQ_BITS'(az_ff) * SQ_BITS'(az_ff);
      dist_ff <= DIST_BITS'(sx_ff) + DIST_BITS'(sy_ff) + DIST_BITS'(sz_ff);
      if (reset) begin
         tag1_ff <= '0;
         tag2_ff <= '0;
         tag3_ff <= '0;
      end else begin
         tag1_ff <= in_tag;
         tag2_ff <= tag1_ff;
         tag3_ff <= tag2_ff;
      end
   end

   assign out_tag  = tag3_ff;
   assign out_dist = dist_ff;

endmodule

>>> hdl/nearest_segment_window.sv
// Nearest segment window. Holds up to MAX_SEGMENTS 3-D centres (signed
// fixed point, 1/4096 m). A word is taken on a clock edge with start high
// and busy low. Clear and append give no result and leave busy low; the
// block is ready again on the next cycle. An append to a full table is
// dropped. A query reads the stored centres one per cycle from the RAM
// through a single distance pipeline (difference, square, sum), keeps the
// first minimum of the squared distance, then emits one result per cycle
// for each index of the window nearest - span .. nearest + span clipped to
// the table, the final one marked with last. A query keeps busy high through
// the scan, the wait for the distance pipeline and the window; the scan is
// paced by the single RAM read port feeding the pipeline one centre a cycle.
// A query on an empty table gives one result with found low in the next
// cycle. Results appear on rsp_word for exactly one cycle under rsp_strobe;
// there is no back-pressure, so the receiver must take every word as it
// comes. Write csr_wdata (neighbor span) only while the block is idle.
module nearest_segment_window
   import nsw_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  req_type              req_word,
   output logic                 rsp_strobe,
   output rsp_type              rsp_word,
   input  logic                 csr_we,
   input  logic [SPAN_BITS-1:0] csr_wdata
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_WAIT,
      ST_SETUP,
      ST_EMIT
   } state_type;

   state_type            state_ff, state_in;
   logic [CNT_BITS-1:0]  count_ff, count_in;
   logic [SPAN_BITS-1:0] span_ff, span_in;
   logic [CNT_BITS-1:0]  rd_cnt_ff, rd_cnt_in;
   centre_type           point_ff, point_in;
   scan_tag_type         iss_tag_ff, iss_tag_in;
   logic [DIST_BITS-1:0] best_dist_ff, best_dist_in;
   logic [IDX_BITS-1:0]  best_idx_ff, best_idx_in;
   logic [IDX_BITS-1:0]  cur_ff, cur_in;
   logic [IDX_BITS-1:0]  hi_ff, hi_in;
   logic                 rsp_strobe_ff, rsp_strobe_in;
   rsp_type              rsp_word_ff, rsp_word_in;

   logic                 ram_we;
   centre_type           ram_wdata;
   centre_type           ram_rdata;
   scan_tag_type         dist_tag;
   logic [DIST_BITS-1:0] dist_val;
   logic [WIN_BITS-1:0]  win_sum;
   logic [WIN_BITS-1:0]  win_lim;

   nsw_ram #(
      .WIDTH ($bits(centre_type)),
      .DEPTH (MAX_SEGMENTS)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (count_ff[IDX_BITS-1:0]),
      .wr_data (ram_wdata),
      .rd_addr (rd_cnt_ff[IDX_BITS-1:0]),
      .rd_data (ram_rdata)
   );

   nsw_dist u_dist (
      .clock    (clock),
      .reset    (reset),
      .in_tag   (iss_tag_ff),
      .centre   (ram_rdata),
      .point    (point_ff),
      .out_tag  (dist_tag),
      .out_dist (dist_val)
   );

   assign ram_wdata = '{x: req_word.pos_x, y: req_word.pos_y, z: req_word.pos_z};
   assign win_sum   = WIN_BITS'(best_idx_ff) + WIN_BITS'(span_ff);
   assign win_lim   = WIN_BITS'(count_ff) - 1'b1;

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      span_in       = span_ff;
      rd_cnt_in     = rd_cnt_ff;
      point_in      = point_ff;
      best_dist_in  = best_dist_ff;
      best_idx_in   = best_idx_ff;
      cur_in        = cur_ff;
      hi_in         = hi_ff;
      rsp_strobe_in = 1'b0;
      rsp_word_in   = rsp_word_ff;
      ram_we        = 1'b0;
      iss_tag_in    = '0;

      if (csr_we) begin
         span_in = csr_wdata;
      end

      // track the running minimum; strict less-than keeps the lowest index
      if (dist_tag.valid) begin
         if (dist_tag.index == '0 || dist_val < best_dist_ff) begin
            best_dist_in = dist_val;
            best_idx_in  = dist_tag.index;
         end
      end

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               case (req_word.command)
                  CMD_CLEAR: begin
                     count_in = '0;
                  end
                  CMD_APPEND: begin
                     if (count_ff < CNT_BITS'(MAX_SEGMENTS)) begin
                        ram_we   = 1'b1;
                        count_in = count_ff + 1'b1;
                     end
                  end
                  CMD_QUERY: begin
                     point_in = ram_wdata;
                     if (count_ff == '0) begin
                        rsp_strobe_in = 1'b1;
                        rsp_word_in   = '{found: 1'b0, closest_index: '0,
                                          segment_index: '0, last: 1'b1};
                     end else begin
                        rd_cnt_in = '0;
                        state_in  = ST_SCAN;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_SCAN: begin
            // issue one centre read per cycle
            iss_tag_in.valid = 1'b1;
            iss_tag_in.index = rd_cnt_ff[IDX_BITS-1:0];
            iss_tag_in.last  = (rd_cnt_ff == count_ff - 1'b1);
            rd_cnt_in        = rd_cnt_ff + 1'b1;
            if (iss_tag_in.last) begin
               state_in = ST_WAIT;
            end
         end
         ST_WAIT: begin
            if (dist_tag.valid && dist_tag.last) begin
               state_in = ST_SETUP;
            end
         end
         ST_SETUP: begin
            cur_in = (WIN_BITS'(best_idx_ff) >= WIN_BITS'(span_ff)) ?
                     IDX_BITS'(win_sum - WIN_BITS'(span_ff) - WIN_BITS'(span_ff)) : '0;
            hi_in  = (win_sum > win_lim) ? IDX_BITS'(win_lim) : IDX_BITS'(win_sum);
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            rsp_strobe_in = 1'b1;
            rsp_word_in   = '{found: 1'b1, closest_index: best_idx_ff,
                              segment_index: cur_ff, last: (cur_ff == hi_ff)};
            cur_in        = cur_ff + 1'b1;
            if (cur_ff == hi_ff) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      rd_cnt_ff    <= rd_cnt_in;
      point_ff     <= point_in;
      best_dist_ff <= best_dist_in;
      best_idx_ff  <= best_idx_in;
      cur_ff       <= cur_in;
      hi_ff        <= hi_in;
      rsp_word_ff  <= rsp_word_in;
      if (reset) begin
         state_ff      <= ST_IDLE;
         count_ff      <= '0;
         span_ff       <= SPAN_RESET;
         rsp_strobe_ff <= 1'b0;
         iss_tag_ff    <= '0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         span_ff       <= span_in;
         rsp_strobe_ff <= rsp_strobe_in;
         iss_tag_ff    <= iss_tag_in;
      end
   end

   assign busy       = (state_ff != ST_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_word   = rsp_word_ff;

   // an empty-table answer is always a single, final word
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe_ff && !rsp_word_ff.found |-> rsp_word_ff.last)
      else $error("empty-table result not marked last");

   // window cursor never passes the upper bound
   assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_EMIT |-> cur_ff <= hi_ff)
      else $error("window cursor beyond upper bound");

   // fill count never exceeds the table depth
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_BITS'(MAX_SEGMENTS))
      else $error("segment count overflow");

   // distances only come back while a scan is in flight
   assert property (@(posedge clock) disable iff (reset)
      dist_tag.valid |-> (state_ff == ST_SCAN || state_ff == ST_WAIT))
      else $error("stray distance outside scan");

endmodule

>>> tb/nearest_segment_window_tb.sv
`timescale 1ns / 100ps

module nearest_segment_window_tb;
   import nsw_pkg::*;

   // command code the block must ignore
   localparam logic [1:0] CMD_SPARE = 2'd3;

   localparam logic signed [COORD_BITS-1:0] COORD_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
   localparam logic signed [COORD_BITS-1:0] COORD_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};

   localparam int RANDOM_WORDS  = 280;
   localparam int SETTLE_CYCLES = 8;     // clear/append never raise busy
   localparam int DRAIN_CYCLES  = 40;
   localparam int IDLE_LIMIT    = 2000;  // full scan plus longest sender gap, many times over
   localparam int SHOW_LIMIT    = 10;

   // Tracks the centre table and span, and holds the window words that
   // each accepted query is due to produce, oldest first.
   class window_tracker;
      centre_type           centres[MAX_SEGMENTS];
      int unsigned          fill;
      logic [SPAN_BITS-1:0] span;
      rsp_type              window_due[$];
      int unsigned          errors;
      int unsigned          shown;

      function new();
         fill   = 0;
         span   = SPAN_RESET;
         errors = 0;
         shown  = 0;
      endfunction

      function void flag(string what);
         errors++;
         if (shown < SHOW_LIMIT) begin
            shown++;
            $display("%0t: %s", $time, what);
         end
      endfunction

      // |a - b| of two coordinates, exact in ABS_BITS
      function logic [ABS_BITS-1:0] gap_mag(logic signed [COORD_BITS-1:0] a,
                                            logic signed [COORD_BITS-1:0] b);
         logic signed [ABS_BITS-1:0] d;
         d = {a[COORD_BITS-1], a} - {b[COORD_BITS-1], b};
         return d[ABS_BITS-1] ? -d : d;
      endfunction

      function logic [DIST_BITS-1:0] dist_sq(centre_type c, req_type p);
         logic [DIST_BITS-1:0] mx;
         logic [DIST_BITS-1:0] my;
         logic [DIST_BITS-1:0] mz;
         mx = DIST_BITS'(gap_mag(c.x, p.pos_x));
         my = DIST_BITS'(gap_mag(c.y, p.pos_y));
         mz = DIST_BITS'(gap_mag(c.z, p.pos_z));
         return mx * mx + my * my + mz * mz;
      endfunction

      function void set_span(logic [SPAN_BITS-1:0] v);
         span = v;
      endfunction

      function void take_word(req_type w);
         int                   best;
         int                   lo;
         int                   hi;
         logic [DIST_BITS-1:0] best_sq;
         logic [DIST_BITS-1:0] sq;
         rsp_type              r;
         case (w.command)
            CMD_CLEAR: begin
               fill = 0;
            end
            CMD_APPEND: begin
               // a full table drops the append
               if (fill < MAX_SEGMENTS) begin
                  centres[fill] = {w.pos_x, w.pos_y, w.pos_z};
                  fill++;
               end
            end
            CMD_QUERY: begin
               if (fill == 0) begin
                  r.found         = 1'b0;
                  r.closest_index = '0;
                  r.segment_index = '0;
                  r.last          = 1'b1;
                  window_due.insert(window_due.size(), r);
               end else begin
                  best    = 0;
                  best_sq = dist_sq(centres[0], w);
                  for (int i = 1; i < fill; i++) begin
                     sq = dist_sq(centres[i], w);
                     // strict compare: the first minimum wins a tie
                     if (sq < best_sq) begin
                        best_sq = sq;
                        best    = i;
                     end
                  end
                  lo = (best >= int'(span)) ? best - int'(span) : 0;
                  hi = best + int'(span);
                  if (hi > int'(fill) - 1) hi = int'(fill) - 1;
                  for (int i = lo; i <= hi; i++) begin
                     r.found         = 1'b1;
                     r.closest_index = IDX_BITS'(best);
                     r.segment_index = IDX_BITS'(i);
                     r.last          = (i == hi);
                     window_due.insert(window_due.size(), r);
                  end
               end
            end
            default: ;
         endcase
      endfunction

      function void match_word(rsp_type got);
         rsp_type want;
         if (window_due.size() == 0) begin
            flag($sformatf("unexpected result word found=%0b nearest=%0d segment=%0d last=%0b",
                           got.found, got.closest_index, got.segment_index, got.last));
            return;
         end
         want = window_due.pop_front();
         if (got.found !== want.found || got.closest_index !== want.closest_index ||
             got.segment_index !== want.segment_index || got.last !== want.last) begin
            flag($sformatf({"mismatch: expected found=%0b nearest=%0d segment=%0d last=%0b,",
                            " got found=%0b nearest=%0d segment=%0d last=%0b"},
                           want.found, want.closest_index, want.segment_index, want.last,
                           got.found, got.closest_index, got.segment_index, got.last));
         end
      endfunction

      function int unsigned waiting();
         return window_due.size();
      endfunction

      function void close_out();
         if (window_due.size() != 0) begin
            flag($sformatf("%0d expected result words never arrived", window_due.size()));
         end
      endfunction
   endclass

   logic                 clock;
   logic                 reset     = 1'b1;
   logic                 start     = 1'b0;
   logic                 busy;
   req_type              req_word  = '0;
   logic                 rsp_strobe;
   rsp_type              rsp_word;
   logic                 csr_we    = 1'b0;
   logic [SPAN_BITS-1:0] csr_wdata = SPAN_RESET;

   window_tracker tracker  = new();
   int unsigned   sent     = 0;   // words accepted so far
   int unsigned   idle_run = 0;   // cycles since the last handshake on either side
   bit            calm     = 1'b0;

   nearest_segment_window dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_word   (req_word),
      .rsp_strobe (rsp_strobe),
      .rsp_word   (rsp_word),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Take every result word in the cycle it is offered, and watch for a
   // stall: a long run of cycles with no handshake on either side.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_strobe === 1'b1) tracker.match_word(rsp_word);
         if ((start && busy === 1'b0) || rsp_strobe === 1'b1) begin
            idle_run <= 0;
         end else begin
            idle_run <= idle_run + 1;
         end
         if (idle_run >= IDLE_LIMIT) begin
            $display("status: fail");
            $finish;
         end
      end
   end

   function automatic req_type pack_word(logic [1:0] cmd,
                                         logic signed [COORD_BITS-1:0] x,
                                         logic signed [COORD_BITS-1:0] y,
                                         logic signed [COORD_BITS-1:0] z);
      req_type w;
      w.command = cmd;
      w.pos_x   = x;
      w.pos_y   = y;
      w.pos_z   = z;
      return w;
   endfunction

   // Tight mode keeps coordinates in a tiny cube so that ties are common;
   // otherwise mix full-range values, small values near zero and the two extremes.
   function automatic logic signed [COORD_BITS-1:0] pick_coord(bit tight);
      if (tight) return COORD_BITS'($urandom_range(0, 8)) - COORD_BITS'(4);
      case ($urandom_range(0, 9))
         0: return COORD_MAX;
         1: return COORD_MIN;
         2: return COORD_BITS'($urandom_range(0, 64)) - COORD_BITS'(32);
         default: return COORD_BITS'($urandom);
      endcase
   endfunction

   // Mostly back to back, now and then a short pause, rarely a long one.
   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (calm || r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // Offer one word after an optional pause and hold it until the block
   // takes it. Start stays high on return so the next word can follow
   // straight on; callers that pause must drop start themselves.
   task automatic send_word(req_type w, int unsigned gap);
      if (gap != 0) begin
         start    <= 1'b0;
         req_word <= pack_word(2'($urandom), COORD_BITS'($urandom), COORD_BITS'($urandom),
                               COORD_BITS'($urandom));
         repeat (gap) @(posedge clock);
      end
      start    <= 1'b1;
      req_word <= w;
      do @(posedge clock); while (busy !== 1'b0);
      tracker.take_word(w);
      sent++;
   endtask

   // Write the span only once the block is idle: drop start, drain the
   // outstanding window, let a trailing clear or append settle.
   task automatic write_span(logic [SPAN_BITS-1:0] v);
      start <= 1'b0;
      while (tracker.waiting() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      while (busy !== 1'b0) @(posedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= v;
      @(posedge clock);
      csr_we <= 1'b0;
      tracker.set_span(v);
   endtask

   initial begin
      int unsigned base;
      int unsigned phase_no;
      int unsigned size;
      int unsigned queries;
      int unsigned k;
      bit          full;
      bit          tight;
      centre_type  c;
      centre_type  placed[$];

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // ---- directed part ----
      // query an empty table straight out of reset
      send_word(pack_word(CMD_QUERY, '0, '0, '0), pick_gap());
      // spare code with every coordinate at its maximum: must change nothing
      send_word(pack_word(CMD_SPARE, COORD_MAX, COORD_MAX, COORD_MAX), pick_gap());
      // corner centres, then a duplicate pair at the origin for a tie
      send_word(pack_word(CMD_APPEND, COORD_MAX, COORD_MAX, COORD_MAX), pick_gap());
      send_word(pack_word(CMD_APPEND, COORD_MIN, COORD_MIN, COORD_MIN), pick_gap());
      send_word(pack_word(CMD_APPEND, '0, '0, '0), pick_gap());
      send_word(pack_word(CMD_APPEND, '0, '0, '0), pick_gap());
      // farthest-possible distances against the opposite corner
      send_word(pack_word(CMD_QUERY, COORD_MIN, COORD_MIN, COORD_MIN), pick_gap());
      send_word(pack_word(CMD_QUERY, COORD_MAX, COORD_MAX, COORD_MAX), pick_gap());
      send_word(pack_word(CMD_QUERY, '0, '0, '0), pick_gap());
      send_word(pack_word(CMD_QUERY, COORD_MAX, COORD_MIN, '0), pick_gap());
      // narrowest window
      write_span('0);
      send_word(pack_word(CMD_QUERY, '0, '0, '0), pick_gap());
      // widest window, clamped on both sides
      write_span(SPAN_BITS'(31));
      send_word(pack_word(CMD_QUERY, 20'sd1, 20'sd1, 20'sd1), pick_gap());
      // clear carries junk coordinates; then an equidistant pair
      send_word(pack_word(CMD_CLEAR, COORD_MAX, COORD_MIN, COORD_MAX), pick_gap());
      send_word(pack_word(CMD_APPEND, 20'sd16, '0, '0), pick_gap());
      send_word(pack_word(CMD_APPEND, -20'sd16, '0, '0), pick_gap());
      send_word(pack_word(CMD_QUERY, '0, '0, '0), pick_gap());
      send_word(pack_word(CMD_QUERY, '0, '0, -20'sd5), pick_gap());
      // clear back to empty, spare code in between must not disturb it
      send_word(pack_word(CMD_CLEAR, COORD_MIN, COORD_MIN, COORD_MIN), pick_gap());
      send_word(pack_word(CMD_QUERY, COORD_MIN, '0, COORD_MAX), pick_gap());
      send_word(pack_word(CMD_SPARE, COORD_MIN, COORD_MIN, COORD_MIN), pick_gap());
      send_word(pack_word(CMD_QUERY, '0, '0, '0), pick_gap());

      // ---- random part: clear, fill, query, with some noise ----
      base     = sent;
      phase_no = 0;
      while (sent - base < RANDOM_WORDS) begin
         phase_no++;
         // two phases overfill the table; the first of them with the widest span
         full  = (phase_no == 2 || phase_no == 9);
         calm  = ($urandom_range(0, 3) == 0);
         tight = ($urandom_range(0, 2) == 0);
         if (phase_no == 2) begin
            write_span(SPAN_BITS'(31));
         end else if ($urandom_range(0, 1) == 0) begin
            case ($urandom_range(0, 3))
               0: write_span('0);
               1: write_span(SPAN_BITS'(31));
               default: write_span(SPAN_BITS'($urandom_range(0, 31)));
            endcase
         end

         // usually start from an empty table; now and then keep growing the old one
         if (full || $urandom_range(0, 4) != 0) begin
            send_word(pack_word(CMD_CLEAR, pick_coord(1'b0), pick_coord(1'b0),
                                pick_coord(1'b0)), pick_gap());
            placed.delete();
         end

         if (full) size = MAX_SEGMENTS + 2;
         else if ($urandom_range(0, 3) == 0) size = $urandom_range(9, 20);
         else size = $urandom_range(0, 8);

         for (int n = 0; n < size; n++) begin
            // repeat an earlier centre now and then to force ties
            if (placed.size() != 0 && $urandom_range(0, 7) == 0) begin
               c = placed[$urandom_range(0, placed.size() - 1)];
            end else begin
               c = {pick_coord(tight), pick_coord(tight), pick_coord(tight)};
            end
            send_word(pack_word(CMD_APPEND, c.x, c.y, c.z), pick_gap());
            placed.insert(placed.size(), c);
            if ($urandom_range(0, 15) == 0) begin
               send_word(pack_word(CMD_SPARE, pick_coord(1'b0), pick_coord(1'b0),
                                   pick_coord(1'b0)), pick_gap());
            end
         end

         queries = $urandom_range(2, 6);
         for (int n = 0; n < queries; n++) begin
            if (placed.size() != 0 && $urandom_range(0, 2) != 0) begin
               // aim at a stored centre, on a full table first at the middle slot
               k = (full && n == 0) ? 31 : $urandom_range(0, placed.size() - 1);
               c = placed[k];
               if ($urandom_range(0, 1) == 1) begin
                  c.x = c.x + COORD_BITS'($urandom_range(0, 2)) - COORD_BITS'(1);
               end
            end else begin
               c = {pick_coord(tight), pick_coord(tight), pick_coord(tight)};
            end
            send_word(pack_word(CMD_QUERY, c.x, c.y, c.z), pick_gap());
            // slip an append in between queries now and then
            if ($urandom_range(0, 9) == 0) begin
               c = {pick_coord(tight), pick_coord(tight), pick_coord(tight)};
               send_word(pack_word(CMD_APPEND, c.x, c.y, c.z), pick_gap());
               placed.insert(placed.size(), c);
            end
         end
      end

      // drop start, drain what is still due, then wait out DRAIN_CYCLES
      start <= 1'b0;
      while (tracker.waiting() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      tracker.close_out();
      if (tracker.errors == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

>>> sim.f
hdl/nsw_pkg.sv
hdl/nsw_ram.sv
hdl/nsw_dist.sv
hdl/nearest_segment_window.sv
tb/nearest_segment_window_tb.sv
